// File: rtl/keyword_lexer_macros.svh
// assertion macros for the keyword lexer
`ifndef KEYWORD_LEXER_MACROS_SVH
`define KEYWORD_LEXER_MACROS_SVH

// property must hold on every clock outside reset
`define KL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define KL_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: rtl/kl_pkg.sv
// shared types, constants and keyword tables of the keyword lexer
`timescale 1ns / 1ps

package kl_pkg;

  localparam int NAME_LEN_DEFAULT   = 32;
  localparam int STRING_LEN_DEFAULT = 48;
  localparam int LINE_W             = 16;
  localparam int KW_COUNT           = 9;

  // token kinds
  localparam logic [2:0] KIND_KEYWORD = 3'd0;
  localparam logic [2:0] KIND_IDENT   = 3'd1;
  localparam logic [2:0] KIND_STRING  = 3'd2;
  localparam logic [2:0] KIND_CHAR    = 3'd3;
  localparam logic [2:0] KIND_END     = 3'd4;

  // result register load selects
  localparam logic [2:0] OUT_CHAR  = 3'd0;
  localparam logic [2:0] OUT_SLASH = 3'd1;
  localparam logic [2:0] OUT_KW    = 3'd2;
  localparam logic [2:0] OUT_TEXT  = 3'd3;
  localparam logic [2:0] OUT_EMPTY = 3'd4;
  localparam logic [2:0] OUT_END   = 3'd5;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_UNDER   = 8'h5F;

  // keyword text, right justified, first character in the highest used byte
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    "whileok", "print", "input", "schema", "rewind",
    "curr", "currency", "exit", "abort"
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd7, 4'd5, 4'd5, 4'd6, 4'd6, 4'd4, 4'd8, 4'd4, 4'd5
  };
  localparam logic [2:0] KW_CODE [KW_COUNT] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd5, 3'd6, 3'd7
  };

  function automatic logic [7:0] kw_char(input int k, input logic [7:0] idx);
    int pos;
    pos = int'(KW_LEN[k]) - 1 - int'(idx);
    if (pos < 0) begin
      return 8'd0;
    end
    return KW_TEXT[k][8*pos +: 8];
  endfunction

  typedef struct packed {
    logic       capture;
    logic       word_start;
    logic       word_add;
    logic       str_start;
    logic       str_add;
    logic       rd_start;
    logic       out_load;
    logic [2:0] out_sel;
    logic [2:0] text_kind;
  } kl_cmd_t;

  typedef struct packed {
    logic eoi;
    logic space;
    logic alnum;
    logic underscore;
    logic newline;
    logic hash;
    logic slash;
    logic star;
    logic quote;
    logic kw_hit;
    logic len_zero;
    logic text_last;
    logic out_free;
  } kl_status_t;

endpackage

// File: rtl/kl_char_if.sv
// character channel: one source character or end mark per item
`timescale 1ns / 1ps

interface kl_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_of_input;

  modport source (output valid, output in_char, output end_of_input, input ready);
  modport sink (input valid, input in_char, input end_of_input, output ready);
endinterface

// File: rtl/kl_token_if.sv
// token channel: one result per item
`timescale 1ns / 1ps

interface kl_token_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                token_kind;
  logic [7:0]                token_code;
  logic [7:0]                text_char;
  logic                      text_valid;
  logic [kl_pkg::LINE_W-1:0] line_number;
  logic                      truncated;
  logic                      last;

  modport source (
    output valid, output token_kind, output token_code, output text_char,
    output text_valid, output line_number, output truncated, output last,
    input ready
  );
  modport sink (
    input valid, input token_kind, input token_code, input text_char,
    input text_valid, input line_number, input truncated, input last,
    output ready
  );
endinterface

// File: rtl/kl_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module kl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/kl_datapath.sv
// lexer datapath: input latch, text buffer, keyword match, line count, result register
`timescale 1ns / 1ps

module kl_datapath #(
  parameter int NAME_LEN   = kl_pkg::NAME_LEN_DEFAULT,
  parameter int STRING_LEN = kl_pkg::STRING_LEN_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  kl_pkg::kl_cmd_t           cmd,
  output kl_pkg::kl_status_t        status,
  input  logic [7:0]                in_char,
  input  logic                      end_of_input,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                token_kind,
  output logic [7:0]                token_code,
  output logic [7:0]                text_char,
  output logic                      text_valid,
  output logic [kl_pkg::LINE_W-1:0] line_number,
  output logic                      truncated,
  output logic                      last
);

  localparam int STORE_DEPTH = (NAME_LEN - 1 > STRING_LEN) ? NAME_LEN - 1 : STRING_LEN;
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int LW = $clog2(STORE_DEPTH + 1);

  logic [7:0]                   cur_char;
  logic                         cur_eoi;
  logic [kl_pkg::LINE_W-1:0]    line_count;
  logic [LW-1:0]                text_length;
  logic                         overflow;
  logic [kl_pkg::KW_COUNT-1:0]  kw_match;
  logic [LW-1:0]                rd_idx;

  logic [LW-1:0]                kw_idx;
  logic [kl_pkg::KW_COUNT-1:0]  kw_keep;
  logic                         kw_hit;
  logic [2:0]                   kw_code;
  logic                         name_room;
  logic                         str_room;
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [7:0]                   ram_rdata;
  logic                         text_last;
  logic                         out_free;

  assign name_room = text_length < LW'(NAME_LEN - 1);
  assign str_room  = text_length < LW'(STRING_LEN);
  assign text_last = (rd_idx + LW'(1)) == text_length;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    kw_idx = cmd.word_start ? '0 : text_length;
    for (int k = 0; k < kl_pkg::KW_COUNT; k++) begin
      kw_keep[k] = (kw_idx < LW'(kl_pkg::KW_LEN[k])) &&
                   (kl_pkg::kw_char(k, 8'(kw_idx)) == cur_char);
    end
  end

  always_comb begin
    kw_hit  = 1'b0;
    kw_code = '0;
    for (int k = kl_pkg::KW_COUNT - 1; k >= 0; k--) begin
      if (kw_match[k] && text_length == LW'(kl_pkg::KW_LEN[k])) begin
        kw_hit  = 1'b1;
        kw_code = kl_pkg::KW_CODE[k];
      end
    end
  end

  always_comb begin
    status            = '0;
    status.eoi        = cur_eoi;
    status.space      = cur_char inside {8'h20, [8'h09:8'h0D]};
    status.alnum      = cur_char inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
    status.underscore = cur_char == kl_pkg::CH_UNDER;
    status.newline    = cur_char == kl_pkg::CH_NEWLINE;
    status.hash       = cur_char == kl_pkg::CH_HASH;
    status.slash      = cur_char == kl_pkg::CH_SLASH;
    status.star       = cur_char == kl_pkg::CH_STAR;
    status.quote      = cur_char == kl_pkg::CH_QUOTE;
    status.kw_hit     = kw_hit;
    status.len_zero   = text_length == '0;
    status.text_last  = text_last;
    status.out_free   = out_free;
  end

  // text buffer
  assign ram_we    = cmd.word_start || (cmd.word_add && name_room) ||
                     (cmd.str_add && str_room);
  assign ram_waddr = cmd.word_start ? '0 : text_length[AW-1:0];

  kl_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_text_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cur_char),
    .raddr (rd_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_char <= in_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_eoi     <= 1'b0;
      line_count  <= '0;
      text_length <= '0;
      overflow    <= 1'b0;
      kw_match    <= '1;
      rd_idx      <= '0;
    end else begin
      if (cmd.capture) begin
        cur_eoi <= end_of_input;
        if (!end_of_input && in_char == kl_pkg::CH_NEWLINE && line_count != '1) begin
          line_count <= line_count + 1'b1;
        end
      end
      if (cmd.word_start) begin
        text_length <= LW'(1);
        overflow    <= 1'b0;
        kw_match    <= kw_keep;
      end else if (cmd.word_add) begin
        if (name_room) begin
          text_length <= text_length + 1'b1;
          kw_match    <= kw_match & kw_keep;
        end else begin
          overflow <= 1'b1;
          kw_match <= '0;
        end
      end else if (cmd.str_start) begin
        text_length <= '0;
        overflow    <= 1'b0;
      end else if (cmd.str_add) begin
        if (str_room) begin
          text_length <= text_length + 1'b1;
        end else begin
          overflow <= 1'b1;
        end
      end
      if (cmd.rd_start) begin
        rd_idx <= '0;
      end else if (cmd.out_load && cmd.out_sel == kl_pkg::OUT_TEXT) begin
        rd_idx <= rd_idx + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      line_number <= line_count;
      token_code  <= '0;
      text_char   <= '0;
      text_valid  <= 1'b0;
      truncated   <= 1'b0;
      last        <= 1'b1;
      case (cmd.out_sel)
        kl_pkg::OUT_CHAR: begin
          token_kind <= kl_pkg::KIND_CHAR;
          token_code <= cur_char;
        end
        kl_pkg::OUT_SLASH: begin
          token_kind <= kl_pkg::KIND_CHAR;
          token_code <= kl_pkg::CH_SLASH;
        end
        kl_pkg::OUT_KW: begin
          token_kind <= kl_pkg::KIND_KEYWORD;
          token_code <= 8'(kw_code);
        end
        kl_pkg::OUT_TEXT: begin
          token_kind <= cmd.text_kind;
          text_char  <= ram_rdata;
          text_valid <= 1'b1;
          truncated  <= overflow;
          last       <= text_last;
        end
        kl_pkg::OUT_EMPTY: begin
          token_kind <= cmd.text_kind;
          truncated  <= overflow;
        end
        default: begin
          token_kind <= kl_pkg::KIND_END;
        end
      endcase
    end
  end

endmodule

// File: rtl/kl_controller.sv
// lexer controller: lexer mode and token sequencing
`timescale 1ns / 1ps

module kl_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  kl_pkg::kl_status_t status,
  output kl_pkg::kl_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_SLASH   = 3'd2;
  localparam logic [2:0] S_WORD    = 3'd3;
  localparam logic [2:0] S_TEXT    = 3'd4;
  localparam logic [2:0] S_TXT_RD  = 3'd5;
  localparam logic [2:0] S_TXT_OUT = 3'd6;
  localparam logic [2:0] S_FINISH  = 3'd7;

  localparam logic [2:0] M_START  = 3'd0;
  localparam logic [2:0] M_HASH   = 3'd1;
  localparam logic [2:0] M_SLASH  = 3'd2;
  localparam logic [2:0] M_BLOCK  = 3'd3;
  localparam logic [2:0] M_STAR   = 3'd4;
  localparam logic [2:0] M_WORD   = 3'd5;
  localparam logic [2:0] M_STRING = 3'd6;

  localparam logic [1:0] F_NONE  = 2'd0;
  localparam logic [1:0] F_START = 2'd1;
  localparam logic [1:0] F_END   = 2'd2;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] mode;
  logic [2:0] mode_next;
  logic [1:0] follow;
  logic [1:0] follow_next;
  logic [2:0] text_kind;
  logic [2:0] text_kind_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next     = state;
    mode_next      = mode;
    follow_next    = follow;
    text_kind_next = text_kind;
    cmd            = '0;
    cmd.capture    = in_valid && in_ready;
    cmd.text_kind  = text_kind;

    case (state)
      S_IDLE: begin
        if (cmd.capture) begin
          state_next = S_DECODE;
        end
      end

      S_DECODE: begin
        state_next = S_IDLE;
        if (status.eoi) begin
          follow_next = F_END;
          case (mode)
            M_SLASH: state_next = S_SLASH;
            M_WORD: begin
              text_kind_next = kl_pkg::KIND_IDENT;
              state_next     = S_WORD;
            end
            M_STRING: begin
              text_kind_next = kl_pkg::KIND_STRING;
              state_next     = S_TEXT;
            end
            default: state_next = S_FINISH;
          endcase
        end else begin
          case (mode)
            M_START: begin
              follow_next = F_START;
              state_next  = S_FINISH;
            end
            M_HASH: begin
              if (status.newline) begin
                mode_next = M_START;
              end
            end
            M_SLASH: begin
              if (status.star) begin
                mode_next = M_BLOCK;
              end else begin
                follow_next = F_START;
                state_next  = S_SLASH;
              end
            end
            M_BLOCK: begin
              if (status.star) begin
                mode_next = M_STAR;
              end
            end
            M_STAR: begin
              if (status.slash) begin
                mode_next = M_START;
              end else if (!status.star) begin
                mode_next = M_BLOCK;
              end
            end
            M_WORD: begin
              if (status.alnum || status.underscore) begin
                cmd.word_add = 1'b1;
              end else begin
                text_kind_next = kl_pkg::KIND_IDENT;
                follow_next    = F_START;
                state_next     = S_WORD;
              end
            end
            M_STRING: begin
              if (status.quote) begin
                text_kind_next = kl_pkg::KIND_STRING;
                follow_next    = F_NONE;
                state_next     = S_TEXT;
              end else begin
                cmd.str_add = 1'b1;
              end
            end
            default: mode_next = M_START;
          endcase
        end
      end

      S_SLASH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = kl_pkg::OUT_SLASH;
          state_next   = S_FINISH;
        end
      end

      S_WORD: begin
        if (!status.kw_hit) begin
          state_next = S_TEXT;
        end else if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = kl_pkg::OUT_KW;
          state_next   = S_FINISH;
        end
      end

      S_TEXT: begin
        if (!status.len_zero) begin
          cmd.rd_start = 1'b1;
          state_next   = S_TXT_RD;
        end else if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = kl_pkg::OUT_EMPTY;
          state_next   = S_FINISH;
        end
      end

      S_TXT_RD: begin
        state_next = S_TXT_OUT;
      end

      S_TXT_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = kl_pkg::OUT_TEXT;
          state_next   = status.text_last ? S_FINISH : S_TXT_RD;
        end
      end

      S_FINISH: begin
        case (follow)
          F_END: begin
            if (status.out_free) begin
              cmd.out_load = 1'b1;
              cmd.out_sel  = kl_pkg::OUT_END;
              mode_next    = M_START;
              state_next   = S_IDLE;
            end
          end
          F_START: begin
            state_next = S_IDLE;
            if (status.space) begin
              mode_next = M_START;
            end else if (status.hash) begin
              mode_next = M_HASH;
            end else if (status.slash) begin
              mode_next = M_SLASH;
            end else if (status.alnum) begin
              cmd.word_start = 1'b1;
              mode_next      = M_WORD;
            end else if (status.quote) begin
              cmd.str_start = 1'b1;
              mode_next     = M_STRING;
            end else if (status.out_free) begin
              cmd.out_load = 1'b1;
              cmd.out_sel  = kl_pkg::OUT_CHAR;
              mode_next    = M_START;
            end else begin
              state_next = S_FINISH;
            end
          end
          default: begin
            mode_next  = M_START;
            state_next = S_IDLE;
          end
        endcase
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mode      <= M_START;
      follow    <= F_NONE;
      text_kind <= kl_pkg::KIND_IDENT;
    end else begin
      state     <= state_next;
      mode      <= mode_next;
      follow    <= follow_next;
      text_kind <= text_kind_next;
    end
  end

endmodule

// File: rtl/keyword_lexer.sv
// keyword lexer top level: controller, datapath and channel hookup
`timescale 1ns / 1ps
`include "keyword_lexer_macros.svh"

// Character-at-a-time lexer. One source character or end mark is taken per item
// on chars. Tokens leave on tokens, one result per item, and last marks the final
// result of each token. A character in a comment, or one that extends a word or
// string, passes through capture and decode. A character or end mark read in the
// start state then goes on to the finish state, in which it starts a word, string
// or comment, skips white space, or loads its own token. A lone slash or keyword
// result is loaded in its own state before the finish state. Buffered identifier
// or string text is set up in the text state, and a word is first checked for a
// keyword in the word state. Each text character then passes through a read state
// and an output state, because the text buffer has a registered read. A stalled
// sink holds the lexer in the state that loads the result. Input is held off while
// a burst is going out. The result register lets the last result wait for the sink
// while the next character is taken. No clearing pass is needed after reset.
module keyword_lexer #(
  parameter int NAME_LEN   = kl_pkg::NAME_LEN_DEFAULT,
  parameter int STRING_LEN = kl_pkg::STRING_LEN_DEFAULT
) (
  input logic            clk,
  input logic            rst,
  kl_char_if.sink        chars,
  kl_token_if.source     tokens
);

  kl_pkg::kl_cmd_t    cmd;
  kl_pkg::kl_status_t status;
  logic               text_load;

  assign text_load = cmd.out_load && cmd.out_sel == kl_pkg::OUT_TEXT;

  kl_controller u_controller (
    .clk      (clk),
    .rst      (rst),
    .in_valid (chars.valid),
    .in_ready (chars.ready),
    .status   (status),
    .cmd      (cmd)
  );

  kl_datapath #(
    .NAME_LEN   (NAME_LEN),
    .STRING_LEN (STRING_LEN)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .in_char      (chars.in_char),
    .end_of_input (chars.end_of_input),
    .out_valid    (tokens.valid),
    .out_ready    (tokens.ready),
    .token_kind   (tokens.token_kind),
    .token_code   (tokens.token_code),
    .text_char    (tokens.text_char),
    .text_valid   (tokens.text_valid),
    .line_number  (tokens.line_number),
    .truncated    (tokens.truncated),
    .last         (tokens.last)
  );

  `KL_ASSERT(a_one_item_at_a_time, chars.valid && chars.ready |=> !chars.ready, "item overlap")
  `KL_ASSERT_NEVER(a_no_result_overwrite, cmd.out_load && !status.out_free, "result overwritten")
  `KL_ASSERT_NEVER(a_text_needs_length, text_load && status.len_zero, "empty buffer read")

endmodule
